### design/md5_pkg.sv
// Shared types, constants and step functions of the MD5 engine.
// No dependencies; imported by the compression unit, the controller and the top level.
`timescale 1ns / 1ps

package md5_pkg;

	typedef logic [3:0][31:0] word4_t;

	// Control from the controller to the compression unit
	typedef struct packed {
		logic start;   // begin compressing the block in the store
		logic init;    // reload the chaining words with their initial values
	} cmp_ctl_t;

	// Status from the compression unit
	typedef struct packed {
		logic busy;    // a compression is running
		logic done;    // chaining words take their new values at this edge
	} cmp_sts_t;

	localparam word4_t CHAIN_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

	localparam logic [31:0] STEP_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// Message word used by a step
	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [3:0] n;
		logic [3:0] r;
		n = step[3:0];
		case (step[5:4])
			2'd0: r = n;
			2'd1: r = (n << 2) + n + 4'd1;
			2'd2: r = (n << 1) + n + 4'd5;
			default: r = (n << 3) - n;
		endcase
		return r;
	endfunction

	// Rotate left by 0..31
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] dbl;
		dbl = {x, x} << r;
		return dbl[63:32];
	endfunction

endpackage

### design/md5_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the sixteen-word block store.
`timescale 1ns / 1ps

module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/md5_compress.sv
// MD5 compression unit: one step per cycle over words read from the block store.
// Depends on md5_pkg; reads the store through md5_ram's read port.
`timescale 1ns / 1ps

module md5_compress import md5_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmp_ctl_t   ctl,
	output cmp_sts_t   sts,
	output logic [3:0] raddr,
	input  logic [31:0] rdata,
	output word4_t     chain
);

	word4_t      chain_q;
	word4_t      wk_q;        // a, b, c, d
	logic        rd_act_q;
	logic [5:0]  rstep_q;
	logic        vld_s1;
	logic [5:0]  step_s1;
	logic        fin_q;

	logic [31:0] f;
	logic [31:0] sum;
	logic [31:0] nb;

	// Read address is issued in the cycle before its step reaches the datapath
	assign raddr = msg_index(rstep_q);

	// One MD5 step on the word that just came out of the store
	always_comb begin
		case (step_s1[5:4])
			2'd0: f = (wk_q[1] & wk_q[2]) | (~wk_q[1] & wk_q[3]);
			2'd1: f = (wk_q[1] & wk_q[3]) | (wk_q[2] & ~wk_q[3]);
			2'd2: f = wk_q[1] ^ wk_q[2] ^ wk_q[3];
			default: f = wk_q[2] ^ (wk_q[1] | ~wk_q[3]);
		endcase
		sum = wk_q[0] + f + rdata + STEP_K[step_s1];
		nb  = rotl32(sum, ROT_AMT[{step_s1[5:4], step_s1[1:0]}]) + wk_q[1];
	end

	// Read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q <= 1'b0;
			rstep_q  <= '0;
			vld_s1   <= 1'b0;
			step_s1  <= '0;
			fin_q    <= 1'b0;
		end else begin
			if (ctl.start) begin
				rd_act_q <= 1'b1;
				rstep_q  <= '0;
			end else if (rd_act_q) begin
				rstep_q <= rstep_q + 6'd1;
				if (rstep_q == 6'd63) begin
					rd_act_q <= 1'b0;
				end
			end
			vld_s1  <= rd_act_q;
			step_s1 <= rstep_q;
			fin_q   <= vld_s1 && (step_s1 == 6'd63);
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			wk_q <= chain_q;
		end else if (vld_s1) begin
			wk_q <= {wk_q[2], wk_q[1], nb, wk_q[3]};
		end
	end

	// Chaining words: initial values on reset or reinit, feed-forward add after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= CHAIN_IV;
		end else if (ctl.init) begin
			chain_q <= CHAIN_IV;
		end else if (fin_q) begin
			for (int k = 0; k < 4; k++) begin
				chain_q[k] <= chain_q[k] + wk_q[k];
			end
		end
	end

	assign chain    = chain_q;
	assign sts.busy = rd_act_q | vld_s1 | fin_q;
	assign sts.done = fin_q;

`ifndef SYNTHESIS
	// Read pipeline stays in step with the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_act_q |=> vld_s1 && (step_s1 == $past(rstep_q)))
		else $error("compress: read pipeline out of step");

	// Feed-forward add follows exactly the last step
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> $past(vld_s1) && ($past(step_s1) == 6'd63))
		else $error("compress: feed-forward without last step");

	// Reinit never collides with a running compression
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init |-> !sts.busy)
		else $error("compress: reinit during compression");
`endif

endmodule

### design/md5_ctrl.sv
// Controller: byte gathering, bit count, padding sequencer and digest output.
// Depends on md5_pkg; drives the block store write port and the compression unit.
`timescale 1ns / 1ps

module md5_ctrl import md5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  message_byte,
	input  logic        final_byte,
	input  logic        empty_message,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_number,
	output logic        last_word,
	// block store write port
	output logic        mem_we,
	output logic [3:0]  mem_waddr,
	output logic [31:0] mem_wdata,
	// compression unit
	output cmp_ctl_t    cmp_ctl,
	input  cmp_sts_t    cmp_sts,
	input  word4_t      chain
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1;
	localparam logic [2:0] ST_MARK = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [7:0] PAD_MARKER = 8'h80;

	logic [2:0]  state_q;
	logic [5:0]  pos_q;        // next byte slot in the block
	logic [23:0] acc_q;        // lower bytes of the word being gathered
	logic [63:0] len_q;        // message bit count
	logic        fin_pend_q;   // message ends after the running compression
	logic        pad_q;        // padding has begun
	logic        lenblk_q;     // current padding block carries the bit count
	logic [3:0]  wp_q;         // fill word pointer
	logic [1:0]  wn_q;         // digest word being offered

	logic        in_acc;
	logic        byte_acc;
	logic        out_acc;
	logic [31:0] mark_word;
	logic [31:0] fill_word;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign byte_acc  = in_acc && !empty_message;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc   = out_valid && out_ready;

	assign digest_word = chain[wn_q];
	assign word_number = wn_q;
	assign last_word   = (wn_q == 2'd3);

	// Marker word: gathered bytes, then 0x80, then zeros
	always_comb begin
		unique case (pos_q[1:0])
			2'd0: mark_word = {24'h0, PAD_MARKER};
			2'd1: mark_word = {16'h0, PAD_MARKER, acc_q[7:0]};
			2'd2: mark_word = {8'h0, PAD_MARKER, acc_q[15:0]};
			2'd3: mark_word = {PAD_MARKER, acc_q};
			default: mark_word = '0;
		endcase
	end

	// Fill word: zeros, with the bit count in the last two words of the final block
	always_comb begin
		fill_word = '0;
		if (lenblk_q && wp_q == 4'd14) begin
			fill_word = len_q[31:0];
		end else if (lenblk_q && wp_q == 4'd15) begin
			fill_word = len_q[63:32];
		end
	end

	// Block store write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[5:2];
		mem_wdata = {message_byte, acc_q};
		if (byte_acc && pos_q[1:0] == 2'd3) begin
			mem_we = 1'b1;
		end else if (state_q == ST_MARK) begin
			mem_we    = 1'b1;
			mem_wdata = mark_word;
		end else if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = wp_q;
			mem_wdata = fill_word;
		end
	end

	// Compression start and reinit
	always_comb begin
		cmp_ctl.start = 1'b0;
		cmp_ctl.init  = out_acc && (wn_q == 2'd3);
		if (byte_acc && pos_q == 6'd63) begin
			cmp_ctl.start = 1'b1;
		end else if (state_q == ST_MARK && pos_q[5:2] == 4'd15) begin
			cmp_ctl.start = 1'b1;
		end else if (state_q == ST_FILL && wp_q == 4'd15) begin
			cmp_ctl.start = 1'b1;
		end
	end

	// Gathered bytes below the current word boundary
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			case (pos_q[1:0])
				2'd0: acc_q[7:0]   <= message_byte;
				2'd1: acc_q[15:8]  <= message_byte;
				2'd2: acc_q[23:16] <= message_byte;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			len_q      <= '0;
			fin_pend_q <= 1'b0;
			pad_q      <= 1'b0;
			lenblk_q   <= 1'b0;
			wp_q       <= '0;
			wn_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && empty_message) begin
						state_q <= ST_MARK;
					end else if (in_acc) begin
						pos_q <= pos_q + 6'd1;
						len_q <= len_q + 64'd8;
						if (pos_q == 6'd63) begin
							fin_pend_q <= final_byte;
							state_q    <= ST_COMP;
						end else if (final_byte) begin
							state_q <= ST_MARK;
						end
					end
				end
				ST_MARK: begin
					pad_q    <= 1'b1;
					// bit count fits behind the marker only below byte 56
					lenblk_q <= (pos_q[5:2] < 4'd14);
					if (pos_q[5:2] == 4'd15) begin
						state_q <= ST_COMP;
					end else begin
						wp_q    <= pos_q[5:2] + 4'd1;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (wp_q == 4'd15) begin
						state_q <= ST_COMP;
					end else begin
						wp_q <= wp_q + 4'd1;
					end
				end
				ST_COMP: begin
					if (cmp_sts.done) begin
						if (!pad_q) begin
							state_q    <= fin_pend_q ? ST_MARK : ST_IDLE;
							fin_pend_q <= 1'b0;
						end else if (lenblk_q) begin
							wn_q    <= '0;
							state_q <= ST_OUT;
						end else begin
							lenblk_q <= 1'b1;
							wp_q     <= '0;
							state_q  <= ST_FILL;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						wn_q <= wn_q + 2'd1;
						if (wn_q == 2'd3) begin
							pos_q    <= '0;
							len_q    <= '0;
							pad_q    <= 1'b0;
							lenblk_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A compression is started only when the unit is free
	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_ctl.start |-> !cmp_sts.busy)
		else $error("ctrl: compression started while busy");

	// The block store is not written while a compression reads it
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !cmp_sts.busy)
		else $error("ctrl: block store written during compression");

	// Input and output sides are never open together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ctrl: input and output open together");

	// After the last digest word the message state is back at its start
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && wn_q == 2'd3) |=> (pos_q == 6'd0 && len_q == 64'd0 && !pad_q))
		else $error("ctrl: state not cleared after digest");
`endif

endmodule

### design/md5_message_digest.sv
// MD5 message digest engine, one message byte per input item. A byte is taken
// every cycle while a block is being gathered; when the 64th byte of a block
// arrives the input stalls while the compression unit runs its 64 steps, one
// per cycle, over the block store RAM (behind its registered read, and followed
// by one feed-forward add). At the end of a message the padding
// sequencer writes one marker word and fill words up to the end of the block,
// one word a cycle, plus a whole second block of sixteen fill words when the
// bit count no longer fits, and runs one or two more compressions; the four
// digest words then leave low word first, and the engine starts over with a
// fresh message.
// Top level: depends on md5_pkg, md5_ram, md5_compress and md5_ctrl.
`timescale 1ns / 1ps

module md5_message_digest import md5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] message_byte
	input  logic        s_tlast,   // final_byte
	input  logic        s_tuser,   // empty_message
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [1:0]  m_tuser,   // [1:0] word_number
	output logic        m_tlast    // last_word
);

	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;
	logic [31:0] mem_rdata;
	cmp_ctl_t    cmp_ctl;
	cmp_sts_t    cmp_sts;
	word4_t      chain;

	// Sixteen-word block store
	md5_ram #(
		.WIDTH(32),
		.DEPTH(16)
	) u_block_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	md5_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cmp_ctl),
		.sts    (cmp_sts),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata),
		.chain  (chain)
	);

	md5_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.message_byte  (s_tdata),
		.final_byte    (s_tlast),
		.empty_message (s_tuser),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.digest_word   (m_tdata),
		.word_number   (m_tuser),
		.last_word     (m_tlast),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.cmp_ctl       (cmp_ctl),
		.cmp_sts       (cmp_sts),
		.chain         (chain)
	);

endmodule
